[rtl/core/gww_pkg.sv]
// Package with the shared types and constants of the greedy word wrap block.
package gww_pkg;

   localparam int BYTE_W   = 8;
   localparam int CFG_W    = 12;
   localparam int COLUMN_W = 13;

   localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CFG_W-1:0]  LINE_WIDTH_RESET = 12'd80;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEP,
      ST_WORD,
      ST_NL
   } gww_state_type;

   typedef struct packed {
      logic store;
      logic flush_start;
      logic load_sep;
      logic load_char;
      logic load_nl;
      logic run_end;
   } gww_cmd_type;

   typedef struct packed {
      logic word_empty;
      logic line_started;
      logic last_char;
      logic out_free;
   } gww_status_type;

endpackage

[rtl/core/gww_ifs.sv]
// Channel interfaces of the greedy word wrap block.
interface gww_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;
   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface gww_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       word_truncated;
   modport source (output valid, output out_byte, output run_last, output word_truncated,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input word_truncated,
                 output ready);
endinterface

interface gww_csr_if;
   logic        valid;
   logic        ready;
   logic [11:0] line_width;
   modport source (output valid, output line_width, input ready);
   modport sink (input valid, input line_width, output ready);
endinterface

[rtl/core/gww_ctrl.sv]
// Controller state machine that sequences the emission of each word's run.
module gww_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [7:0]              req_text_byte,
   input  logic                    req_end_of_text,
   output logic                    req_ready,
   input  gww_pkg::gww_status_type status,
   output gww_pkg::gww_cmd_type    cmd
);
   import gww_pkg::*;

   gww_state_type state_ff;
   gww_state_type state_in;
   logic          eot_pending_ff;
   logic          eot_pending_in;
   logic          is_delim;

   assign is_delim = (req_text_byte == CHAR_SPACE) || (req_text_byte == CHAR_NEWLINE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         eot_pending_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         eot_pending_ff <= eot_pending_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      eot_pending_in = eot_pending_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_end_of_text) begin
                  eot_pending_in = 1'b1;
                  if (status.word_empty) begin
                     state_in = ST_NL;
                  end else begin
                     cmd.flush_start = 1'b1;
                     state_in = status.line_started ? ST_SEP : ST_WORD;
                  end
               end else if (is_delim) begin
                  if (!status.word_empty) begin
                     eot_pending_in  = 1'b0;
                     cmd.flush_start = 1'b1;
                     state_in = status.line_started ? ST_SEP : ST_WORD;
                  end
               end else begin
                  cmd.store = 1'b1;
               end
            end
         end
         ST_SEP: begin
            if (status.out_free) begin
               cmd.load_sep = 1'b1;
               state_in = ST_WORD;
            end
         end
         ST_WORD: begin
            if (status.out_free) begin
               cmd.load_char = 1'b1;
               cmd.run_end   = status.last_char && !eot_pending_ff;
               if (status.last_char) begin
                  state_in = eot_pending_ff ? ST_NL : ST_IDLE;
               end
            end
         end
         ST_NL: begin
            if (status.out_free) begin
               cmd.load_nl    = 1'b1;
               eot_pending_in = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/gww_dp.sv]
// Datapath with the word buffer, line state, width register and output register.
module gww_dp #(
   parameter int MAX_WORD = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_text_byte,
   input  logic                    csr_valid,
   input  logic [11:0]             csr_line_width,
   input  gww_pkg::gww_cmd_type    cmd,
   output gww_pkg::gww_status_type status,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_run_last,
   output logic                    rsp_word_truncated
);
   import gww_pkg::*;

   localparam int LEN_W = $clog2(MAX_WORD + 1);
   localparam int IDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

   logic [BYTE_W-1:0]   word_store [MAX_WORD];
   logic [LEN_W-1:0]    word_len_ff;
   logic [IDX_W-1:0]    rd_cnt_ff;
   logic [COLUMN_W-1:0] column_ff;
   logic                line_started_ff;
   logic                overflow_ff;
   logic                fits_ff;
   logic [CFG_W-1:0]    line_width_ff;
   logic                rsp_valid_ff;
   logic [BYTE_W-1:0]   out_byte_ff;
   logic                run_last_ff;
   logic                trunc_ff;
   logic [COLUMN_W:0]   need;
   logic                fits;
   logic                last_char;
   logic                out_free;

   assign need      = {1'b0, column_ff} + (COLUMN_W + 1)'(word_len_ff) + (COLUMN_W + 1)'(1);
   assign fits      = line_started_ff && (need <= (COLUMN_W + 1)'(line_width_ff));
   assign last_char = (LEN_W'(rd_cnt_ff) + LEN_W'(1)) == word_len_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign status.word_empty   = (word_len_ff == '0);
   assign status.line_started = line_started_ff;
   assign status.last_char    = last_char;
   assign status.out_free     = out_free;

   always_ff @(posedge clock) begin
      if (cmd.store && (word_len_ff < LEN_W'(MAX_WORD))) begin
         word_store[word_len_ff[IDX_W-1:0]] <= req_text_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_len_ff     <= '0;
         column_ff       <= '0;
         line_started_ff <= 1'b0;
         overflow_ff     <= 1'b0;
         line_width_ff   <= LINE_WIDTH_RESET;
         rsp_valid_ff    <= 1'b0;
         rd_cnt_ff       <= '0;
         fits_ff         <= 1'b0;
      end else begin
         if (csr_valid) begin
            line_width_ff <= csr_line_width;
         end
         if (cmd.store) begin
            if (word_len_ff < LEN_W'(MAX_WORD)) begin
               word_len_ff <= word_len_ff + LEN_W'(1);
            end else begin
               overflow_ff <= 1'b1;
            end
         end
         if (cmd.flush_start) begin
            rd_cnt_ff       <= '0;
            fits_ff         <= fits;
            line_started_ff <= 1'b1;
            if (fits) begin
               column_ff <= need[COLUMN_W-1:0];
            end else begin
               column_ff <= COLUMN_W'(word_len_ff);
            end
         end
         if (cmd.load_char) begin
            rd_cnt_ff <= rd_cnt_ff + IDX_W'(1);
            if (last_char) begin
               word_len_ff <= '0;
               overflow_ff <= 1'b0;
            end
         end
         if (cmd.load_nl) begin
            column_ff       <= '0;
            line_started_ff <= 1'b0;
            word_len_ff     <= '0;
            overflow_ff     <= 1'b0;
         end
         if (cmd.load_sep || cmd.load_char || cmd.load_nl) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sep) begin
         out_byte_ff <= fits_ff ? CHAR_SPACE : CHAR_NEWLINE;
         run_last_ff <= 1'b0;
         trunc_ff    <= overflow_ff;
      end else if (cmd.load_char) begin
         out_byte_ff <= word_store[rd_cnt_ff];
         run_last_ff <= cmd.run_end;
         trunc_ff    <= overflow_ff;
      end else if (cmd.load_nl) begin
         out_byte_ff <= CHAR_NEWLINE;
         run_last_ff <= 1'b1;
         trunc_ff    <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_run_last       = run_last_ff;
   assign rsp_word_truncated = trunc_ff;

endmodule

[rtl/core/greedy_word_wrap_core.sv]
// Top level of the greedy word wrap block: controller, datapath and assertions.
// A character item causes no result and leaves the input ready for the next item.
// A delimiter that ends a word, or an end-of-text item, moves the controller to its
// separator, word or newline state; the emit sequencer then loads one byte per cycle
// into the single output register while it is free. A flushing item stalls the input
// until its run of at most MAX_WORD + 2 bytes is loaded, which waits on the result side.
// Synchronous active-high reset clears the word, the line state and sets the width to 80.
module greedy_word_wrap_core #(
   parameter int MAX_WORD = 32
) (
   input  logic      clock,
   input  logic      reset,
   gww_req_if.sink   req,
   gww_rsp_if.source rsp,
   gww_csr_if.sink   csr
);
   import gww_pkg::*;

   gww_cmd_type    cmd;
   gww_status_type status;
   logic           eot_pending;

   assign csr.ready = 1'b1;

   gww_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req.valid),
      .req_text_byte   (req.text_byte),
      .req_end_of_text (req.end_of_text),
      .req_ready       (req.ready),
      .status          (status),
      .cmd             (cmd)
   );

   gww_dp #(
      .MAX_WORD (MAX_WORD)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_text_byte      (req.text_byte),
      .csr_valid          (csr.valid),
      .csr_line_width     (csr.line_width),
      .cmd                (cmd),
      .status             (status),
      .rsp_ready          (rsp.ready),
      .rsp_valid          (rsp.valid),
      .rsp_out_byte       (rsp.out_byte),
      .rsp_run_last       (rsp.run_last),
      .rsp_word_truncated (rsp.word_truncated)
   );

   assign eot_pending = req.valid && req.ready && req.end_of_text;

   a_eot_busy: assert property (@(posedge clock) disable iff (reset)
      eot_pending |=> !req.ready)
      else $error("end-of-text item did not start a flush");

   a_char_idle: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && !req.end_of_text && cmd.store) |=> req.ready)
      else $error("character item left the controller busy");

   a_skip_idle: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && !req.end_of_text && status.word_empty && !cmd.store)
      |=> req.ready)
      else $error("delimiter with no pending word caused work");

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_sep, cmd.load_char, cmd.load_nl}))
      else $error("more than one output byte loaded in a cycle");

endmodule
